FILE: rtl/hch_pkg.sv
// Shared types and constants for the heightmap cell hillshade block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package hch_pkg;

  localparam int MAX_CELLS_DEF   = 256;
  localparam int HEIGHT_BITS_DEF = 24;
  localparam int HEIGHT_FRAC_DEF = 8;
  localparam int NORMAL_FRAC_DEF = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CELLS_W    = 9;
  localparam int SUN_W      = 16;
  localparam int SUN_FRAC   = 14;

  localparam int SQ_W   = 24;
  localparam int SUM_W  = 50;
  localparam int ROOT_W = 26;
  localparam int REM_W  = 27;
  localparam int MUL_W  = 25;
  localparam int PROD_W = 50;
  localparam int ACC_W  = 51;
  localparam int TM_W   = 58;

  localparam int SHADE_MAX   = 254;
  localparam int SHADE_SHIFT = 7;

  localparam logic [CELLS_W-1:0] CELLS_RST = 9'd256;
  localparam logic signed [SUN_W-1:0] SUN_X_RST = 16'sd1622;
  localparam logic signed [SUN_W-1:0] SUN_Y_RST = 16'sd16222;
  localparam logic signed [SUN_W-1:0] SUN_Z_RST = 16'sd1622;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS = 2'd0,
    REG_SUN_X = 2'd1,
    REG_SUN_Y = 2'd2,
    REG_SUN_Z = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_LOAD,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DOT,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/hch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hch_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/heightmap_cell_hillshade.sv
// Top level of the heightmap cell hillshade block: line store, sequencer and shared
// multiplier, root and divide unit. Depends on hch_pkg and hch_ram.
`timescale 1ns / 1ps

//  channel  signals                                   direction
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i            in (write only)
//  in       in_valid_i/in_ready_o, height_i, first_sample_i   in
//  out      out_valid_o/out_ready_i, shade_o, cell_x_o, cell_y_o, last_cell_o  out
//
//  A beat that closes no cell passes ST_RD_A, ST_RD_B and ST_RD_C back to ST_IDLE. A
//  shaded cell then runs three passes of ST_LOAD, ST_SHIFT (right shifts for wide
//  height steps), ST_SQ, a 25-step square root and three bit-serial divides (skipped
//  at zero length), then ST_DOT and ST_OUT. Reset clears state, counters, left sample
//  and output valid and loads the config defaults; the line store is not cleared. A
//  finished shade waits in the output register while the next beat is taken.

module heightmap_cell_hillshade #(
  parameter int MAX_CELLS   = hch_pkg::MAX_CELLS_DEF,
  parameter int HEIGHT_BITS = hch_pkg::HEIGHT_BITS_DEF,
  parameter int HEIGHT_FRAC = hch_pkg::HEIGHT_FRAC_DEF,
  parameter int NORMAL_FRAC = hch_pkg::NORMAL_FRAC_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hch_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hch_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [HEIGHT_BITS-1:0]    height_i,
  input  logic                             first_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       shade_o,
  output logic [7:0]                       cell_x_o,
  output logic [7:0]                       cell_y_o,
  output logic                             last_cell_o
);

  import hch_pkg::*;

  localparam int CNTW = $clog2(MAX_CELLS + 1);
  localparam int VW0  = (HEIGHT_BITS + 1 > NORMAL_FRAC + 3) ? HEIGHT_BITS + 1 : NORMAL_FRAC + 3;
  localparam int VW   = (VW0 > HEIGHT_FRAC + 2) ? VW0 : HEIGHT_FRAC + 2;
  localparam int AW   = (VW > SQ_W + 1) ? VW : SQ_W + 1;
  localparam int NW   = NORMAL_FRAC + 2;
  localparam int QW   = NORMAL_FRAC + 1;
  localparam int CW   = $clog2(NORMAL_FRAC + 1);
  localparam logic signed [VW-1:0]    Z_ONE = VW'(1) << HEIGHT_FRAC;
  localparam logic signed [NW-1:0]    N_ONE = NW'(1) << NORMAL_FRAC;
  localparam logic signed [ACC_W-1:0] T_ONE = ACC_W'(1) << (NORMAL_FRAC + SUN_FRAC);
  localparam logic [SUM_W-1:0]        BIT_INIT = SUM_W'(1) << (SUM_W - 2);

  state_e state_q, state_d;

  logic [CELLS_W-1:0]         cells_q;
  logic signed [SUN_W-1:0]    sun_q [3];
  logic [CNTW-1:0]            colcnt_q, colcnt_d, rowcnt_q, rowcnt_d;
  logic signed [HEIGHT_BITS-1:0] left_q, left_d;
  logic                       out_valid_q;

  logic [CNTW-1:0]            col_q, col_d, row_q, row_d, w_q, w_d;
  logic                       need_q, need_d, last_q, last_d;
  logic signed [HEIGHT_BITS-1:0] h00_q, h00_d, h01_q, h01_d, h10_q, h10_d, h11_q, h11_d;
  logic [AW-1:0]              a_q [3];
  logic [AW-1:0]              a_d [3];
  logic                       sgn_q [3];
  logic                       sgn_d [3];
  logic signed [NW-1:0]       nv_q [3][3];
  logic signed [NW-1:0]       nv_d [3][3];
  logic [1:0]                 pass_q, pass_d, idx_q, idx_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [SUM_W-1:0]           root_q, root_d, bit_q, bit_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [QW-1:0]              q_q, q_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [7:0]                 shade_q, cell_x_q, cell_y_q;
  logic                       last_cell_q;

  logic [CNTW-1:0]            wcfg, cc, rc, ccl, rcl, colm1;
  logic                       ram_we;
  logic [CNTW-1:0]            ram_waddr, ram_raddr;
  logic [HEIGHT_BITS-1:0]     ram_wdata, ram_rdata;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic [1:0]                 sidx;
  logic signed [VW-1:0]       v [3];
  logic [SUM_W-1:0]           rb;
  logic [ROOT_W-1:0]          len;
  logic [REM_W-1:0]           trial;
  logic                       ge;
  logic [QW-1:0]              qfin;
  logic signed [ACC_W-1:0]    t;
  logic signed [TM_W-1:0]     tm, u;
  logic [7:0]                 shade_c;
  logic                       out_load;

  hch_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (MAX_CELLS + 1)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (cells_q == '0) begin
      wcfg = CNTW'(1);
    end else if (int'(cells_q) > MAX_CELLS) begin
      wcfg = CNTW'(MAX_CELLS);
    end else begin
      wcfg = CNTW'(cells_q);
    end
    cc  = first_sample_i ? '0 : colcnt_q;
    rc  = first_sample_i ? '0 : rowcnt_q;
    ccl = (cc > wcfg) ? wcfg : cc;
    rcl = (rc > wcfg) ? wcfg : rc;
  end

  assign colm1   = (col_q == '0) ? '0 : col_q - CNTW'(1);
  assign sidx    = (idx_q == 2'd3) ? 2'd0 : idx_q;
  assign rb      = root_q + bit_q;
  assign len     = root_q[ROOT_W-1:0];
  assign trial   = (cnt_q == '0) ? REM_W'(a_q[sidx][SQ_W-1:0]) : {rem_q[REM_W-2:0], 1'b0};
  assign ge      = (trial >= REM_W'(len));
  assign qfin    = {q_q[QW-2:0], ge};
  assign prod_d  = mul_a * mul_b;

  assign t  = acc_q + T_ONE;
  assign tm = (TM_W'(t) <<< SHADE_SHIFT) - TM_W'(t);
  assign u  = tm >>> (NORMAL_FRAC + SUN_FRAC);
  always_comb begin
    if (t <= 0) begin
      shade_c = '0;
    end else if (u > TM_W'(SHADE_MAX)) begin
      shade_c = 8'(SHADE_MAX);
    end else begin
      shade_c = 8'(u);
    end
  end

  always_comb begin
    unique case (pass_q)
      2'd0: begin
        v[0] = VW'(h00_q) - VW'(h01_q);
        v[1] = VW'(h00_q) - VW'(h10_q);
        v[2] = Z_ONE;
      end
      2'd1: begin
        v[0] = VW'(h10_q) - VW'(h11_q);
        v[1] = VW'(h01_q) - VW'(h11_q);
        v[2] = Z_ONE;
      end
      default: begin
        v[0] = VW'(nv_q[0][0]) + VW'(nv_q[1][0]);
        v[1] = VW'(nv_q[0][1]) + VW'(nv_q[1][1]);
        v[2] = VW'(nv_q[0][2]) + VW'(nv_q[1][2]);
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    colcnt_d = colcnt_q;
    rowcnt_d = rowcnt_q;
    left_d   = left_q;
    col_d    = col_q;
    row_d    = row_q;
    w_d      = w_q;
    need_d   = need_q;
    last_d   = last_q;
    h00_d    = h00_q;
    h01_d    = h01_q;
    h10_d    = h10_q;
    h11_d    = h11_q;
    a_d      = a_q;
    sgn_d    = sgn_q;
    nv_d     = nv_q;
    pass_d   = pass_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    root_d   = root_q;
    bit_d    = bit_q;
    rem_d    = rem_q;
    q_d      = q_q;
    cnt_d    = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = colm1;
    ram_wdata = h10_q;
    ram_raddr = colm1;
    mul_a     = $signed({1'b0, a_q[sidx][SQ_W-1:0]});
    mul_b     = $signed({1'b0, a_q[sidx][SQ_W-1:0]});
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          h11_d  = height_i;
          h10_d  = left_q;
          left_d = height_i;
          col_d  = ccl;
          row_d  = rcl;
          w_d    = wcfg;
          need_d = (rcl != '0) && (ccl != '0);
          last_d = (rcl == wcfg) && (ccl == wcfg);
          if (ccl == wcfg) begin
            colcnt_d = '0;
            rowcnt_d = (rcl == wcfg) ? '0 : rcl + CNTW'(1);
          end else begin
            colcnt_d = ccl + CNTW'(1);
            rowcnt_d = rcl;
          end
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        ram_raddr = col_q;
        ram_we    = (col_q != '0);
        h00_d     = ram_rdata;
        state_d   = ST_RD_C;
      end
      ST_RD_C: begin
        h01_d     = ram_rdata;
        ram_we    = (col_q == w_q);
        ram_waddr = w_q;
        ram_wdata = h11_q;
        pass_d    = 2'd0;
        state_d   = need_q ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          sgn_d[i] = v[i][VW-1];
          a_d[i]   = AW'($unsigned(v[i][VW-1] ? -v[i] : v[i]));
        end
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if ((|a_q[0][AW-1:SQ_W]) || (|a_q[1][AW-1:SQ_W]) || (|a_q[2][AW-1:SQ_W])) begin
          for (int i = 0; i < 3; i++) begin
            a_d[i] = a_q[i] >> 1;
          end
        end else begin
          idx_d   = 2'd0;
          acc_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (idx_q != 2'd0) begin
          acc_d = acc_q + ACC_W'(prod_q);
        end
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          root_d  = '0;
          bit_d   = BIT_INIT;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (acc_q[SUM_W-1:0] >= rb) begin
          acc_d  = ACC_W'(acc_q[SUM_W-1:0] - rb);
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          idx_d   = 2'd0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (len == '0) begin
          nv_d[pass_q][0] = '0;
          nv_d[pass_q][1] = '0;
          nv_d[pass_q][2] = N_ONE;
          idx_d = 2'd2;
        end else begin
          rem_d = ge ? trial - REM_W'(len) : trial;
          q_d   = (cnt_q == '0) ? QW'(ge) : qfin;
          cnt_d = cnt_q + CW'(1);
          if (cnt_q == CW'(NORMAL_FRAC)) begin
            nv_d[pass_q][sidx] = sgn_q[sidx] ? -$signed(NW'(qfin)) : $signed(NW'(qfin));
            cnt_d = '0;
            idx_d = idx_q + 2'd1;
          end
        end
        if ((len == '0) || ((cnt_q == CW'(NORMAL_FRAC)) && (idx_q == 2'd2))) begin
          if (pass_q == 2'd2) begin
            idx_d   = 2'd0;
            acc_d   = '0;
            state_d = ST_DOT;
          end else begin
            pass_d  = pass_q + 2'd1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_DOT: begin
        mul_a = MUL_W'(nv_q[2][sidx]);
        mul_b = MUL_W'(sun_q[sidx]);
        if (idx_q != 2'd0) begin
          acc_d = acc_q + ACC_W'(prod_q);
        end
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      colcnt_q    <= '0;
      rowcnt_q    <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      cells_q     <= CELLS_RST;
      sun_q[0]    <= SUN_X_RST;
      sun_q[1]    <= SUN_Y_RST;
      sun_q[2]    <= SUN_Z_RST;
    end else begin
      state_q  <= state_d;
      colcnt_q <= colcnt_d;
      rowcnt_q <= rowcnt_d;
      left_q   <= left_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CELLS: cells_q  <= cfg_data_i[CELLS_W-1:0];
          REG_SUN_X: sun_q[0] <= cfg_data_i;
          REG_SUN_Y: sun_q[1] <= cfg_data_i;
          REG_SUN_Z: sun_q[2] <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    w_q    <= w_d;
    need_q <= need_d;
    last_q <= last_d;
    h00_q  <= h00_d;
    h01_q  <= h01_d;
    h10_q  <= h10_d;
    h11_q  <= h11_d;
    a_q    <= a_d;
    sgn_q  <= sgn_d;
    nv_q   <= nv_d;
    pass_q <= pass_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    q_q    <= q_d;
    cnt_q  <= cnt_d;
    if (out_load) begin
      shade_q     <= shade_c;
      cell_x_q    <= 8'(col_q - CNTW'(1));
      cell_y_q    <= 8'(row_q - CNTW'(1));
      last_cell_q <= last_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign shade_o     = shade_q;
  assign cell_x_o    = cell_x_q;
  assign cell_y_o    = cell_y_q;
  assign last_cell_o = last_cell_q;

endmodule
